// ----- sv/color_blob_centroid_detector_assert.svh -----
// Assertion macros for the color blob centroid detector.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef COLOR_BLOB_CENTROID_DETECTOR_ASSERT_SVH
`define COLOR_BLOB_CENTROID_DETECTOR_ASSERT_SVH

// Same-cycle implication.
`define CBCD_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cbcd: same-cycle check failed");

// Next-cycle implication.
`define CBCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cbcd: next-cycle check failed");

`endif

// ----- sv/cbcd_pkg.sv -----
// Constants, register map and types for the color blob centroid detector.
// No dependencies.
package cbcd_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned CEN_W   = 11;
  localparam int unsigned SUM_W   = 30;
  localparam int unsigned CNT_W   = 21;
  localparam int unsigned ASP_W   = 10;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned DIV_STEPS   = SUM_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [SUM_W-1:0]   SUM_MAX = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX = '1;
  localparam logic [COORD_W-1:0] BOX_MAX = '1;
  localparam logic [CEN_W-1:0]   CEN_NONE = '1;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t REG_LUMA_LOW  = 3'd0;
  localparam cfg_idx_t REG_LUMA_HIGH = 3'd1;
  localparam cfg_idx_t REG_BLUE_LOW  = 3'd2;
  localparam cfg_idx_t REG_BLUE_HIGH = 3'd3;
  localparam cfg_idx_t REG_RED_LOW   = 3'd4;
  localparam cfg_idx_t REG_RED_HIGH  = 3'd5;
  localparam cfg_idx_t REG_MIN_PIX   = 3'd6;
  localparam cfg_idx_t REG_MIN_ASP   = 3'd7;

  localparam logic [PIX_W-1:0] RST_LUMA_LOW  = 8'd30;
  localparam logic [PIX_W-1:0] RST_LUMA_HIGH = 8'd220;
  localparam logic [PIX_W-1:0] RST_BLUE_LOW  = 8'd60;
  localparam logic [PIX_W-1:0] RST_BLUE_HIGH = 8'd130;
  localparam logic [PIX_W-1:0] RST_RED_LOW   = 8'd125;
  localparam logic [PIX_W-1:0] RST_RED_HIGH  = 8'd255;
  localparam logic [CNT_W-1:0] RST_MIN_PIX   = 21'd500;
  localparam logic [ASP_W-1:0] RST_MIN_ASP   = 10'd40;

endpackage

// ----- sv/color_blob_centroid_detector.sv -----
// Color blob centroid detector: YUV422 window match, sums, box, centroid.
// Depends on cbcd_pkg and color_blob_centroid_detector_assert.svh.
// A pixel pair passes through the transfer, then one step per pixel through the accumulator.
// A frame-end pair adds an aspect check and two 30-step restoring divisions on one subtractor;
// its result is registered in ST_STORE. Input is not ready during that work.
// Reset loads register defaults and clears sums, count and box; no clearing pass.
`include "color_blob_centroid_detector_assert.svh"

module color_blob_centroid_detector (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // APB configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [4:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // pixel pair stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // chroma_u[7:0], luma_first[15:8], chroma_v[23:16], luma_second[31:24],
  // column[41:32], row[51:42], zero[55:52]
  input  logic [cbcd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tlast,   // frame_end
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // centroid_x[10:0], centroid_y[21:11], match_count[42:22], zero[47:43]
  output logic [cbcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tuser    // found
);

  import cbcd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIX_FIRST,
    ST_PIX_SECOND,
    ST_CHECK,
    ST_DIV,
    ST_STORE
  } state_e;

  state_e state_q, state_d;

  logic [PIX_W-1:0]   luma_low_q, luma_high_q, blue_low_q, blue_high_q;
  logic [PIX_W-1:0]   red_low_q, red_high_q;
  logic [CNT_W-1:0]   min_pix_q;
  logic [ASP_W-1:0]   min_asp_q;

  logic [PIX_W-1:0]   u_q, y1_q, v_q, y2_q;
  logic [COORD_W-1:0] col_q, row_q;
  logic               last_q;

  logic [SUM_W-1:0]   x_sum_q, y_sum_q;
  logic [CNT_W-1:0]   pixel_total_q;
  logic [COORD_W-1:0] box_left_q, box_right_q, box_top_q, box_bottom_q;

  logic [CNT_W-1:0]     rem_q;
  logic [SUM_W-1:0]     dvd_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 div_sel_q;
  logic                 div_ok_q;
  logic                 found_q;
  logic [CEN_W-1:0]     cx_q;

  logic               out_valid_q, out_found_q;
  logic [CEN_W-1:0]   out_cx_q, out_cy_q;
  logic [CNT_W-1:0]   out_cnt_q;

  logic               cfg_wr;
  cfg_idx_t           cfg_idx;

  logic               pix_step, chroma_ok, pix_hit;
  logic [PIX_W-1:0]   pix_luma;
  logic [CEN_W-1:0]   pix_x;
  logic [COORD_W-1:0] box_x;
  logic [SUM_W:0]     x_add, y_add;

  logic [CEN_W-1:0]   box_w, box_h;
  logic [CNT_W-1:0]   asp_prod, h_scaled;
  logic               found_d;

  logic [CNT_W:0]     trial;
  logic               trial_ok;
  logic [CNT_W-1:0]   rem_d;
  logic [SUM_W-1:0]   dvd_d;

  logic               store_go;

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_LUMA_LOW:  prdata = 32'(luma_low_q);
      REG_LUMA_HIGH: prdata = 32'(luma_high_q);
      REG_BLUE_LOW:  prdata = 32'(blue_low_q);
      REG_BLUE_HIGH: prdata = 32'(blue_high_q);
      REG_RED_LOW:   prdata = 32'(red_low_q);
      REG_RED_HIGH:  prdata = 32'(red_high_q);
      REG_MIN_PIX:   prdata = 32'(min_pix_q);
      REG_MIN_ASP:   prdata = 32'(min_asp_q);
      default:       prdata = '0;
    endcase
  end

  // shared pixel accumulate path
  assign pix_step  = (state_q == ST_PIX_FIRST) || (state_q == ST_PIX_SECOND);
  assign pix_luma  = (state_q == ST_PIX_FIRST) ? y1_q : y2_q;
  assign pix_x     = (state_q == ST_PIX_FIRST) ? {1'b0, col_q} : ({1'b0, col_q} + 11'd1);
  assign box_x     = pix_x[CEN_W-1] ? BOX_MAX : pix_x[COORD_W-1:0];
  assign chroma_ok = (u_q >= blue_low_q) && (u_q <= blue_high_q) &&
                     (v_q >= red_low_q) && (v_q <= red_high_q);
  assign pix_hit   = pix_step && chroma_ok && (pix_luma >= luma_low_q) &&
                     (pix_luma <= luma_high_q);
  assign x_add     = {1'b0, x_sum_q} + (SUM_W+1)'(pix_x);
  assign y_add     = {1'b0, y_sum_q} + (SUM_W+1)'(row_q);

  // aspect test
  assign box_w    = (box_right_q > box_left_q) ?
                    ({1'b0, box_right_q} - {1'b0, box_left_q} + 11'd1) : 11'd1;
  assign box_h    = (box_bottom_q > box_top_q) ?
                    ({1'b0, box_bottom_q} - {1'b0, box_top_q} + 11'd1) : 11'd1;
  assign asp_prod = CNT_W'(min_asp_q) * CNT_W'(box_w);
  assign h_scaled = CNT_W'({box_h, 4'b0000});
  assign found_d  = (pixel_total_q >= min_pix_q) && (h_scaled >= asp_prod);

  // restoring divider step
  assign trial    = {rem_q, dvd_q[SUM_W-1]} - {1'b0, pixel_total_q};
  assign trial_ok = !trial[CNT_W];
  assign rem_d    = trial_ok ? trial[CNT_W-1:0] : {rem_q[CNT_W-2:0], dvd_q[SUM_W-1]};
  assign dvd_d    = {dvd_q[SUM_W-2:0], trial_ok};

  assign store_go = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:       if (s_axis_tvalid) state_d = ST_PIX_FIRST;
      ST_PIX_FIRST:  state_d = ST_PIX_SECOND;
      ST_PIX_SECOND: state_d = last_q ? ST_CHECK : ST_IDLE;
      ST_CHECK:      state_d = (found_d && (pixel_total_q != '0)) ? ST_DIV : ST_STORE;
      ST_DIV: begin
        if ((cnt_q == DIV_CNT_W'(DIV_STEPS-1)) && div_sel_q) state_d = ST_STORE;
      end
      ST_STORE:      if (store_go) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      luma_low_q    <= RST_LUMA_LOW;
      luma_high_q   <= RST_LUMA_HIGH;
      blue_low_q    <= RST_BLUE_LOW;
      blue_high_q   <= RST_BLUE_HIGH;
      red_low_q     <= RST_RED_LOW;
      red_high_q    <= RST_RED_HIGH;
      min_pix_q     <= RST_MIN_PIX;
      min_asp_q     <= RST_MIN_ASP;
      u_q           <= '0;
      y1_q          <= '0;
      v_q           <= '0;
      y2_q          <= '0;
      col_q         <= '0;
      row_q         <= '0;
      last_q        <= 1'b0;
      x_sum_q       <= '0;
      y_sum_q       <= '0;
      pixel_total_q <= '0;
      box_left_q    <= BOX_MAX;
      box_right_q   <= '0;
      box_top_q     <= BOX_MAX;
      box_bottom_q  <= '0;
      rem_q         <= '0;
      dvd_q         <= '0;
      cnt_q         <= '0;
      div_sel_q     <= 1'b0;
      div_ok_q      <= 1'b0;
      found_q       <= 1'b0;
      cx_q          <= '0;
      out_valid_q   <= 1'b0;
      out_found_q   <= 1'b0;
      out_cx_q      <= '0;
      out_cy_q      <= '0;
      out_cnt_q     <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_wr) begin
        case (cfg_idx)
          REG_LUMA_LOW:  luma_low_q  <= pwdata[PIX_W-1:0];
          REG_LUMA_HIGH: luma_high_q <= pwdata[PIX_W-1:0];
          REG_BLUE_LOW:  blue_low_q  <= pwdata[PIX_W-1:0];
          REG_BLUE_HIGH: blue_high_q <= pwdata[PIX_W-1:0];
          REG_RED_LOW:   red_low_q   <= pwdata[PIX_W-1:0];
          REG_RED_HIGH:  red_high_q  <= pwdata[PIX_W-1:0];
          REG_MIN_PIX:   min_pix_q   <= pwdata[CNT_W-1:0];
          REG_MIN_ASP:   min_asp_q   <= pwdata[ASP_W-1:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        u_q    <= s_axis_tdata[7:0];
        y1_q   <= s_axis_tdata[15:8];
        v_q    <= s_axis_tdata[23:16];
        y2_q   <= s_axis_tdata[31:24];
        col_q  <= s_axis_tdata[41:32];
        row_q  <= s_axis_tdata[51:42];
        last_q <= s_axis_tlast;
      end

      if (pix_hit) begin
        x_sum_q <= x_add[SUM_W] ? SUM_MAX : x_add[SUM_W-1:0];
        y_sum_q <= y_add[SUM_W] ? SUM_MAX : y_add[SUM_W-1:0];
        if (pixel_total_q != CNT_MAX) pixel_total_q <= pixel_total_q + CNT_W'(1);
        if (box_x < box_left_q)   box_left_q   <= box_x;
        if (box_x > box_right_q)  box_right_q  <= box_x;
        if (row_q < box_top_q)    box_top_q    <= row_q;
        if (row_q > box_bottom_q) box_bottom_q <= row_q;
      end

      if (state_q == ST_CHECK) begin
        found_q   <= found_d;
        div_ok_q  <= found_d && (pixel_total_q != '0);
        dvd_q     <= x_sum_q;
        rem_q     <= '0;
        cnt_q     <= '0;
        div_sel_q <= 1'b0;
      end

      if (state_q == ST_DIV) begin
        if (cnt_q == DIV_CNT_W'(DIV_STEPS-1)) begin
          if (!div_sel_q) begin
            cx_q      <= dvd_d[CEN_W-1:0];
            dvd_q     <= y_sum_q;
            rem_q     <= '0;
            cnt_q     <= '0;
            div_sel_q <= 1'b1;
          end else begin
            dvd_q <= dvd_d;
            rem_q <= rem_d;
          end
        end else begin
          dvd_q <= dvd_d;
          rem_q <= rem_d;
          cnt_q <= cnt_q + DIV_CNT_W'(1);
        end
      end

      if ((state_q == ST_STORE) && store_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      if ((state_q == ST_STORE) && store_go) begin
        out_found_q   <= found_q;
        out_cx_q      <= div_ok_q ? cx_q : CEN_NONE;
        out_cy_q      <= div_ok_q ? dvd_q[CEN_W-1:0] : CEN_NONE;
        out_cnt_q     <= pixel_total_q;
        x_sum_q       <= '0;
        y_sum_q       <= '0;
        pixel_total_q <= '0;
        box_left_q    <= BOX_MAX;
        box_right_q   <= '0;
        box_top_q     <= BOX_MAX;
        box_bottom_q  <= '0;
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = {5'b00000, out_cnt_q, out_cy_q, out_cx_q};

  `CBCD_ASSERT_HOLDS(a_rem_below_divisor, state_q == ST_DIV, rem_q < pixel_total_q)
  `CBCD_ASSERT_HOLDS(a_box_ordered, pixel_total_q != '0, box_left_q <= box_right_q)
  `CBCD_ASSERT_HOLDS(a_miss_no_centroid, out_valid_q && !out_found_q, (out_cx_q == CEN_NONE) && (out_cy_q == CEN_NONE))
  `CBCD_ASSERT_NEXT(a_store_clears, (state_q == ST_STORE) && store_go, (pixel_total_q == '0) && (x_sum_q == '0) && out_valid_q)

endmodule
